/* rtl/linear_interp_resampler_to_48k_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the 48 kHz linear interpolation resampler
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_TO_48K_CORE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TO_48K_CORE_ASSERT_SVH

// same-cycle implication
`define LIR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lir48_pkg.sv */
// ---------------------------------------------------------------------------
// lir48_pkg
// Shared constants and types of the 48 kHz linear interpolation resampler.
// ---------------------------------------------------------------------------
`default_nettype none

package lir48_pkg;

  localparam int unsigned OUT_RATE  = 48000;
  localparam int unsigned RATE_MIN  = (OUT_RATE + 5) / 6;
  localparam int unsigned SPAN_CAP  = 6;

  // 48000 = 375 << 7; divide by 375 through a reciprocal
  localparam int unsigned DIV_SHIFT = 7;
  localparam int unsigned DIV_ODD   = 375;
  localparam logic [23:0] RECIP     = 24'd11453246;

  localparam logic [0:0] REG_SOURCE_RATE   = 1'b0;
  localparam logic [0:0] REG_CHANNELS      = 1'b1;
  localparam logic [1:0] CH_STEREO         = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SPAN,
    SEQ_HOLD
  } seq_state_t;

  typedef struct packed {
    logic signed [15:0] mono;
    logic               last;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic               hold;
    logic               mark;
    logic signed [15:0] prev;
    logic signed [15:0] cur;
    logic        [15:0] phase;
  } issue_t;

  typedef struct packed {
    logic               hold;
    logic               mark;
    logic signed [15:0] cur;
  } side_t;

endpackage

`default_nettype wire

/* rtl/linear_interp_resampler_to_48k_core.sv */
// An accepted frame passes through the frame queue, the sequencer and the datapath registers
//   before its first output sample. The sequencer issues one output request per cycle while
//   the datapath is not stalled, and takes the next frame only once a frame's outputs are done.
// The datapath streams one output per cycle and freezes while a result waits on out_tready.
// Reset (synchronous, rst_n low): clears the clip state and the queues and
//   restores the 48 kHz source rate and mono mode.
// ---------------------------------------------------------------------------
// linear_interp_resampler_to_48k_core
// Linear interpolation resampler from 8..48 kHz mono or stereo to 48 kHz mono.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_to_48k_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // left_sample[15:0], right_sample[31:16]
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // out_sample[15:0]
  output logic        out_tlast
);
  import lir48_pkg::*;

  `include "linear_interp_resampler_to_48k_core_assert.svh"

  logic [15:0] rate_r;
  logic        stereo_r;
  logic [15:0] rate_clamped;

  frame_t      head;
  fifo_stat_t  fifo_stat;
  logic        pop;
  logic        pipe_en;
  logic        issue_valid;
  issue_t      issue;

  assign rate_clamped = (cfg_wdata < 16'(RATE_MIN)) ? 16'(RATE_MIN) :
                        (cfg_wdata > 16'(OUT_RATE)) ? 16'(OUT_RATE) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= 16'(OUT_RATE);
      stereo_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_RATE: rate_r   <= rate_clamped;
        REG_CHANNELS:    stereo_r <= (cfg_wdata[1:0] == CH_STEREO);
        default:         rate_r   <= rate_r;
      endcase
    end
  end

  lir48_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .stereo    (stereo_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  lir48_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .rate        (rate_r),
    .head        (head),
    .fifo_stat   (fifo_stat),
    .pop         (pop),
    .pipe_en     (pipe_en),
    .issue_valid (issue_valid),
    .issue       (issue)
  );

  lir48_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .pipe_en     (pipe_en),
    .issue_valid (issue_valid),
    .issue       (issue),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  `LIR_ASSERT_NEXT(a_issue_hold, issue_valid && !pipe_en, issue_valid && $stable(issue), "stalled request changed")
  `LIR_ASSERT_NEXT(a_queue_fill, in_tvalid && in_tready, !fifo_stat.empty, "accepted frame not queued")
  `LIR_ASSERT_IMPL(a_stall_freeze, out_tvalid && !out_tready, !pipe_en, "datapath moved while output stalled")

endmodule

`default_nettype wire

/* rtl/lir48_fifo.sv */
// ---------------------------------------------------------------------------
// lir48_fifo
// Two-entry frame queue between the front end and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module lir48_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  lir48_pkg::frame_t     push_data,
  input  wire                   pop,
  output lir48_pkg::frame_t     head,
  output lir48_pkg::fifo_stat_t stat
);
  import lir48_pkg::*;

  frame_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

/* rtl/lir48_front.sv */
// ---------------------------------------------------------------------------
// lir48_front
// Accept source frames, fold stereo to mono and queue them.
// ---------------------------------------------------------------------------
`default_nettype none

module lir48_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   stereo,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [31:0]           in_tdata,  // left_sample[15:0], right_sample[31:16]
  input  wire                   in_tlast,
  input  wire                   pop,
  output lir48_pkg::frame_t     head,
  output lir48_pkg::fifo_stat_t stat
);
  import lir48_pkg::*;

  logic signed [15:0] left;
  logic signed [15:0] right;
  logic signed [16:0] sum;
  logic signed [16:0] half;
  frame_t             frame;
  logic               push;

  assign left  = $signed(in_tdata[15:0]);
  assign right = $signed(in_tdata[31:16]);
  assign sum   = 17'(left) + 17'(right);
  // round toward zero
  assign half  = (sum + $signed({16'd0, sum[16]})) >>> 1;

  assign frame.mono = stereo ? half[15:0] : left;
  assign frame.last = in_tlast;

  assign in_tready = ~stat.full;
  assign push      = in_tvalid & in_tready;

  lir48_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (frame),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

endmodule

`default_nettype wire

/* rtl/lir48_seq.sv */
// ---------------------------------------------------------------------------
// lir48_seq
// Walk the phase per queued frame and issue one output request per cycle unless the datapath stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module lir48_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [15:0]           rate,
  input  lir48_pkg::frame_t     head,
  input  lir48_pkg::fifo_stat_t fifo_stat,
  output logic                  pop,
  input  wire                   pipe_en,
  output logic                  issue_valid,
  output lir48_pkg::issue_t     issue
);
  import lir48_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic signed [15:0] prev_r, prev_nxt;
  logic signed [15:0] cur_r, cur_nxt;
  logic               last_r, last_nxt;
  logic               have_r, have_nxt;
  logic        [16:0] phase_r, phase_nxt;
  logic        [2:0]  k_r, k_nxt;

  logic [16:0] r_adv;
  logic [16:0] r_wrap;
  logic [16:0] r_end;
  logic [17:0] r_adv2;
  logic        k_ok;
  logic        k1_ok;
  logic        more_span;
  logic        hold_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      prev_r  <= '0;
      cur_r   <= '0;
      last_r  <= 1'b0;
      have_r  <= 1'b0;
      phase_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
      last_r  <= last_nxt;
      have_r  <= have_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
    end
  end

  assign r_adv     = phase_r + 17'(rate);
  assign r_adv2    = 18'(r_adv) + 18'(rate);
  assign r_wrap    = (phase_r >= 17'(OUT_RATE)) ? phase_r - 17'(OUT_RATE) : 17'd0;
  assign r_end     = (r_adv >= 17'(OUT_RATE)) ? r_adv - 17'(OUT_RATE) : 17'd0;
  assign k_ok      = (k_r < 3'(SPAN_CAP));
  assign k1_ok     = (({1'b0, k_r} + 4'd1) < 4'(SPAN_CAP));
  assign more_span = k1_ok && (r_adv < 17'(OUT_RATE));
  assign hold_any  = (r_end + 17'(rate)) <= 17'(OUT_RATE);

  always_comb begin
    state_nxt   = state_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    have_nxt    = have_r;
    phase_nxt   = phase_r;
    k_nxt       = k_r;
    pop         = 1'b0;
    issue_valid = 1'b0;
    issue.hold  = 1'b0;
    issue.mark  = 1'b0;
    issue.prev  = prev_r;
    issue.cur   = cur_r;
    issue.phase = phase_r[15:0];

    unique case (state_r)
      SEQ_IDLE: begin
        if (!fifo_stat.empty) begin
          pop      = 1'b1;
          cur_nxt  = head.mono;
          last_nxt = head.last;
          k_nxt    = '0;
          if (have_r) begin
            state_nxt = SEQ_SPAN;
          end else begin
            phase_nxt = '0;
            if (head.last) begin
              state_nxt = SEQ_HOLD;
            end else begin
              prev_nxt = head.mono;
              have_nxt = 1'b1;
            end
          end
        end
      end

      SEQ_SPAN: begin
        if (k_ok && (phase_r < 17'(OUT_RATE))) begin
          issue_valid = 1'b1;
          issue.mark  = last_r && !more_span && !hold_any;
          if (pipe_en) begin
            phase_nxt = r_adv;
            k_nxt     = k_r + 3'd1;
          end
        end else begin
          phase_nxt = r_wrap;
          k_nxt     = '0;
          if (last_r) begin
            state_nxt = SEQ_HOLD;
          end else begin
            prev_nxt  = cur_r;
            have_nxt  = 1'b1;
            state_nxt = SEQ_IDLE;
          end
        end
      end

      SEQ_HOLD: begin
        if (k_ok && (r_adv <= 17'(OUT_RATE))) begin
          issue_valid = 1'b1;
          issue.hold  = 1'b1;
          issue.mark  = !(k1_ok && (r_adv2 <= 18'(OUT_RATE)));
          if (pipe_en) begin
            phase_nxt = r_adv;
            k_nxt     = k_r + 3'd1;
          end
        end else begin
          prev_nxt  = '0;
          phase_nxt = '0;
          have_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = SEQ_IDLE;
        end
      end

      default: state_nxt = SEQ_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lir48_pipe.sv */
// ---------------------------------------------------------------------------
// lir48_pipe
// Interpolation datapath: weighted sum, exact divide by 48000, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lir48_pipe (
  input  wire               clk,
  input  wire               rst_n,
  output logic              pipe_en,
  input  wire               issue_valid,
  input  lir48_pkg::issue_t issue,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [15:0]       out_tdata,  // out_sample[15:0]
  output logic              out_tlast
);
  import lir48_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  side_t              s1_r, s2_r, s3_r, s4_r, s5_r, s_in;

  logic signed [33:0] prod1_r, base1_r;
  logic signed [33:0] num2_r;
  logic        [23:0] x3_r, x4_r, x5_r;
  logic               neg3_r, neg4_r, neg5_r;
  logic        [15:0] qe4_r, qe5_r;
  logic        [24:0] t5_r;

  logic               out_valid_r;
  logic        [15:0] out_data_r;
  logic               out_last_r;

  logic signed [16:0] diff;
  logic signed [33:0] prod1_nxt;
  logic signed [33:0] base1_nxt;
  logic        [33:0] num_mag;
  logic        [47:0] recip_prod;
  logic        [24:0] t5_nxt;
  logic        [24:0] rem;
  logic        [16:0] q;
  logic        [16:0] q_signed;

  assign pipe_en = ~out_valid_r | out_tready;

  assign s_in.hold = issue.hold;
  assign s_in.mark = issue.mark;
  assign s_in.cur  = issue.cur;

  assign diff       = 17'(issue.cur) - 17'(issue.prev);
  assign prod1_nxt  = 34'(diff) * 34'($signed({1'b0, issue.phase}));
  assign base1_nxt  = 34'(issue.prev) * $signed(34'(OUT_RATE));
  assign recip_prod = 48'(x3_r) * 48'(RECIP);
  assign t5_nxt     = 25'(qe4_r) * 25'(DIV_ODD);
  assign rem        = 25'(x5_r) - t5_r;
  assign q          = (rem >= 25'(DIV_ODD)) ? 17'(qe5_r) + 17'd1 : 17'(qe5_r);
  assign q_signed   = neg5_r ? 17'd0 - q : q;

  assign num_mag = num2_r[33] ? 34'(-num2_r) : 34'(num2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= issue_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r    <= s_in;
      prod1_r <= prod1_nxt;
      base1_r <= base1_nxt;

      s2_r    <= s1_r;
      num2_r  <= base1_r + prod1_r;

      s3_r    <= s2_r;
      neg3_r  <= num2_r[33];
      x3_r    <= num_mag[DIV_SHIFT+23:DIV_SHIFT];

      s4_r    <= s3_r;
      neg4_r  <= neg3_r;
      x4_r    <= x3_r;
      qe4_r   <= recip_prod[47:32];

      s5_r    <= s4_r;
      neg5_r  <= neg4_r;
      x5_r    <= x4_r;
      qe5_r   <= qe4_r;
      t5_r    <= t5_nxt;

      out_data_r <= s5_r.hold ? s5_r.cur : q_signed[15:0];
      out_last_r <= s5_r.mark;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* test/linear_interp_resampler_to_48k_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_interp_resampler_to_48k_core_tb
// Streams mono and stereo source frames into the 48 kHz resampler at many
// source rates, predicts every interpolated and held output sample with a
// cycle-free model of the phase accumulator, and checks each output sample
// and its end-of-clip mark in order. Both stream sides stall at random.
// ---------------------------------------------------------------------------

module linear_interp_resampler_to_48k_core_tb;
  import lir48_pkg::*;

  localparam longint FULL_SPAN = OUT_RATE;
  localparam longint SLOWEST_RATE = RATE_MIN;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_FRAMES = 285;
  localparam int REPORT_CAP = 40;
  localparam logic [1:0] CH_MONO = 2'd1;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } frame_req_t;

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } sample_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // left_sample[15:0], right_sample[31:16]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // out_sample[15:0]
  logic        out_tlast;

  frame_req_t  pending_frames[$];
  sample_req_t expected_samples[$];
  frame_req_t  next_frame;
  sample_req_t head_sample;
  logic        in_taken;
  logic        steady_flow;
  int          fail_count;
  int          quiet_cycles;

  // Shadow of the block's registers and clip state
  logic [15:0] shadow_rate;
  logic [1:0]  shadow_chans;
  longint      held_mono;
  longint      phase_acc;
  bit          held_valid;

  linear_interp_resampler_to_48k_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic push_sample(input longint value, input logic mark);
    sample_req_t s;
    s.sample = 16'(value);
    s.last = mark;
    expected_samples.insert(expected_samples.size(), s);
  endtask

  task automatic interpolate_frame(input logic signed [15:0] left,
                                   input logic signed [15:0] right, input logic last);
    longint rate;
    longint cur;
    longint pos;
    int     count;
    rate = shadow_rate;
    if (rate < SLOWEST_RATE) rate = SLOWEST_RATE;
    if (rate > FULL_SPAN) rate = FULL_SPAN;
    if (shadow_chans == CH_STEREO) cur = (longint'(left) + longint'(right)) / 2;
    else cur = longint'(left);
    pos = phase_acc;
    count = 0;
    if (held_valid) begin
      for (int k = 0; k < SPAN_CAP && pos < FULL_SPAN; k++) begin
        push_sample((held_mono * (FULL_SPAN - pos) + cur * pos) / FULL_SPAN, 1'b0);
        count++;
        pos += rate;
      end
      pos = (pos >= FULL_SPAN) ? pos - FULL_SPAN : 0;
    end else begin
      pos = 0;
    end
    if (last) begin
      // hold the final sample up to the clip's output count
      for (int k = 0; k < SPAN_CAP && pos + rate <= FULL_SPAN; k++) begin
        push_sample(cur, 1'b0);
        count++;
        pos += rate;
      end
      if (count > 0) expected_samples[expected_samples.size() - 1].last = 1'b1;
      held_mono = 0;
      phase_acc = 0;
      held_valid = 0;
    end else begin
      held_mono = cur;
      phase_acc = pos & 'hFFFF;
      held_valid = 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_rate = 16'd48000;
      shadow_chans = CH_MONO;
      held_mono = 0;
      phase_acc = 0;
      held_valid = 0;
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_RATE: shadow_rate = cfg_wdata;
          REG_CHANNELS: shadow_chans = cfg_wdata[1:0];
          default: ;
        endcase
      end
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) interpolate_frame(in_tdata[15:0], in_tdata[31:16], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $display("%0t: unexpected output: expected none, actual sample %0d last %0b",
                     $time, $signed(out_tdata), out_tlast);
          fail_count++;
        end else begin
          head_sample = expected_samples.pop_front();
          if (out_tdata !== head_sample.sample || out_tlast !== head_sample.last) begin
            if (fail_count < REPORT_CAP)
              $display("%0t: output mismatch: expected sample %0d last %0b, actual sample %0d last %0b",
                       $time, $signed(head_sample.sample), head_sample.last,
                       $signed(out_tdata), out_tlast);
            fail_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_frames.size() > 0 && (steady_flow || $urandom_range(99) >= 37)) begin
          next_frame = pending_frames.pop_front();
          in_tdata <= {next_frame.right, next_frame.left};
          in_tlast <= next_frame.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= steady_flow || $urandom_range(99) >= 37;
    end
  end

  task automatic write_reg(input logic [0:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame(input logic [15:0] left, input logic [15:0] right,
                            input logic last);
    frame_req_t f;
    f.left = left;
    f.right = right;
    f.last = last;
    pending_frames.insert(pending_frames.size(), f);
  endtask

  // Wait until every request is taken and every sample is out, then drain the pipe
  task automatic settle();
    do @(negedge clk);
    while (pending_frames.size() != 0 || in_tvalid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int random_count;
    int phase_no;
    int clip_len;
    int pick;
    logic [15:0] rate;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    steady_flow = 1'b0;
    fail_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: single-frame clip, then a short clip at full rate
    push_frame(16'h7FFF, 16'h0000, 1'b1);
    push_frame(16'h8000, 16'd5, 1'b0);
    push_frame(16'h7FFF, 16'hFFFF, 1'b0);
    push_frame(16'h0000, 16'h0000, 1'b1);
    settle();

    // Slowest rate, stereo: most outputs per frame, averaging toward zero
    write_reg(REG_SOURCE_RATE, 16'd8000);
    write_reg(REG_CHANNELS, 16'(CH_STEREO));
    push_frame(16'h7FFF, 16'h7FFF, 1'b0);
    push_frame(16'h8000, 16'h8000, 1'b0);
    push_frame(16'hFFFF, 16'h0000, 1'b0);
    push_frame(16'h0001, 16'hFFFE, 1'b0);
    push_frame(16'hFFFD, 16'h0000, 1'b1);
    settle();

    // Zero rate saturates up, odd channel count acts as mono
    write_reg(REG_SOURCE_RATE, 16'd0);
    write_reg(REG_CHANNELS, 16'd3);
    push_frame(16'd100, 16'hFF9C, 1'b0);
    push_frame(16'h8000, 16'h7FFF, 1'b1);
    push_frame(16'h8000, 16'h0000, 1'b1);
    settle();

    // Downsampling rate saturates down; change registers in the middle of a clip
    write_reg(REG_SOURCE_RATE, 16'hFFFF);
    write_reg(REG_CHANNELS, 16'd0);
    push_frame(16'd1234, 16'h0000, 1'b0);
    push_frame(-16'sd1234, 16'h0000, 1'b0);
    settle();
    write_reg(REG_SOURCE_RATE, 16'd44100);
    write_reg(REG_CHANNELS, 16'(CH_STEREO));
    push_frame(16'h7FFF, 16'h8000, 1'b0);
    push_frame(16'h4000, 16'h4000, 1'b1);
    settle();

    write_reg(REG_SOURCE_RATE, 16'd7999);
    write_reg(REG_CHANNELS, 16'(CH_MONO));
    push_frame(16'h8000, 16'h0000, 1'b0);
    push_frame(16'h7FFF, 16'h0000, 1'b1);
    settle();

    random_count = 0;
    phase_no = 0;
    while (random_count < RANDOM_FRAMES) begin
      steady_flow <= (phase_no >= 4 && phase_no < 7);
      pick = $urandom_range(0, 9);
      if (pick == 0) rate = 16'($urandom_range(0, 7999));
      else if (pick == 1) rate = 16'($urandom_range(48001, 65535));
      else if (pick == 2) rate = $urandom_range(0, 1) ? 16'd8000 : 16'd48000;
      else rate = 16'($urandom_range(8000, 48000));
      write_reg(REG_SOURCE_RATE, rate);
      if ($urandom_range(0, 3) == 0) write_reg(REG_CHANNELS, 16'($urandom_range(0, 3)));
      else write_reg(REG_CHANNELS, 16'($urandom_range(1, 2)));
      repeat ($urandom_range(1, 4)) begin
        clip_len = $urandom_range(1, 12);
        for (int i = 0; i < clip_len; i++)
          push_frame(pick_sample(), pick_sample(),
                     i == clip_len - 1 && $urandom_range(0, 4) != 0);
        random_count += clip_len;
      end
      settle();
      phase_no++;
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
